// File: design/rcia_pkg.sv
// Package for the range-coalescing ID allocator.
// Holds transaction structs, request/status/state codes and register constants.
// No dependencies.
package rcia_pkg;

  // Configuration port
  localparam int unsigned CFG_AW = 4;
  localparam logic [1:0] REG_MIN_ID        = 2'd0;
  localparam logic [1:0] REG_MAX_ID        = 2'd1;
  localparam logic [1:0] REG_RELEASE_DELAY = 2'd2;

  localparam logic [31:0] MIN_ID_RST        = 32'h0000_0000;
  localparam logic [31:0] MAX_ID_RST        = 32'hFFFF_FFFF;
  localparam logic [31:0] RELEASE_DELAY_RST = 32'd300000;

  // Request codes
  typedef enum logic [2:0] {
    REQ_GET_ID    = 3'd0,
    REQ_ID_TO_KEY = 3'd1,
    REQ_ERASE     = 3'd2,
    REQ_TICK      = 3'd3,
    REQ_CLEANUP   = 3'd4
  } req_e;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_NEW       = 3'd0,
    STAT_EXISTING  = 3'd1,
    STAT_NO_FREE   = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_FULL      = 3'd4,
    STAT_DONE      = 3'd5
  } status_e;

  // Controller states
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_ALLOC_RD,
    S_ALLOC_UPD,
    S_GB_SCAN,
    S_GB_ACT,
    S_SHIFT,
    S_INS,
    S_DONE
  } state_e;

  // Where to go once a range shift finishes
  typedef enum logic [1:0] {
    AFT_DONE,
    AFT_SCAN,
    AFT_INS
  } after_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] key;
    logic [31:0] query_id;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] id;
    logic [63:0] found_key;
    logic [32:0] remaining_ids;
    logic [8:0]  range_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0] min_id;
    logic [31:0] max_id;
    logic [31:0] release_delay;
  } cfg_t;

endpackage

// File: design/rcia_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the entry table and the free-range list. No dependencies.
module rcia_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: design/rcia_cfg.sv
// APB-style configuration registers: min_id, max_id, release_delay.
// Depends on rcia_pkg. Flags a rebuild when either ID bound is written.
module rcia_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rcia_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output rcia_pkg::cfg_t             cfg_o,
  output logic                       rebuild_o
);

  rcia_pkg::cfg_t cfg_q, cfg_d;
  logic           wr;
  logic [1:0]     idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  // Register write decode
  always_comb begin
    cfg_d     = cfg_q;
    rebuild_o = 1'b0;
    if (wr) begin
      unique case (idx)
        rcia_pkg::REG_MIN_ID: begin
          cfg_d.min_id = pwdata;
          rebuild_o    = 1'b1;
        end
        rcia_pkg::REG_MAX_ID: begin
          cfg_d.max_id = pwdata;
          rebuild_o    = 1'b1;
        end
        rcia_pkg::REG_RELEASE_DELAY: cfg_d.release_delay = pwdata;
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      rcia_pkg::REG_MIN_ID:        prdata = cfg_q.min_id;
      rcia_pkg::REG_MAX_ID:        prdata = cfg_q.max_id;
      rcia_pkg::REG_RELEASE_DELAY: prdata = cfg_q.release_delay;
      default:                     prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_id        <= rcia_pkg::MIN_ID_RST;
      cfg_q.max_id        <= rcia_pkg::MAX_ID_RST;
      cfg_q.release_delay <= rcia_pkg::RELEASE_DELAY_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/range_coalescing_id_allocator_core.sv
// Tick and unknown requests go from S_IDLE straight to S_DONE; lookups scan the entry RAM one
// entry per cycle; cleanup adds per freed ID a walk of the range list and, where needed, a
// shift of ranges. One request at a time; the entry scan and the range-list walk go through
// single-read-port RAMs.
// Reset (and any min_id/max_id write) clears all entries and marks and rewrites the initial
// free range in S_INIT before input is accepted; the tick count resets to 0 only on reset.
module range_coalescing_id_allocator_core #(
  parameter int unsigned MAX_ENTRIES = 256,
  parameter int unsigned KEY_BITS    = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rcia_pkg::req_t              in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output rcia_pkg::rsp_t              out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcia_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned AW    = $clog2(MAX_ENTRIES);
  localparam int unsigned SLOTS = MAX_ENTRIES + 1;
  localparam int unsigned RAW   = $clog2(SLOTS);
  localparam int unsigned RW    = $clog2(SLOTS + 1);
  localparam int unsigned EW    = KEY_BITS + 64;

  // Configuration
  rcia_pkg::cfg_t cfg;
  logic           cfg_rebuild;

  rcia_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .cfg_o     (cfg),
    .rebuild_o (cfg_rebuild)
  );

  // Entry RAM: {key, id, mark_time}
  logic          e_we, e_re;
  logic [AW-1:0] e_waddr, e_raddr;
  logic [EW-1:0] e_wdata, e_rdata;

  rcia_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(EW)) u_entry_ram (
    .clk_i,
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .re_i    (e_re),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  // Free-range RAM: {start, end}
  logic           r_we, r_re;
  logic [RAW-1:0] r_waddr, r_raddr;
  logic [63:0]    r_wdata, r_rdata;

  rcia_ram #(.DEPTH(SLOTS), .WIDTH(64)) u_range_ram (
    .clk_i,
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .re_i    (r_re),
    .raddr_i (r_raddr),
    .rdata_o (r_rdata)
  );

  // Registers
  rcia_pkg::state_e  state_q, state_d;
  logic [2:0]        op_q, op_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [31:0]       qid_q, qid_d;
  logic [MAX_ENTRIES-1:0] valid_q, valid_d, pend_q, pend_d;
  logic [AW:0]       scan_addr_q, scan_addr_d;
  logic              rd_pend_q, rd_pend_d;
  logic [AW-1:0]     rd_idx_q, rd_idx_d;
  logic              free_found_q, free_found_d;
  logic [AW-1:0]     free_idx_q, free_idx_d;
  logic [31:0]       tick_q, tick_d;
  logic [RW-1:0]     used_q, used_d;
  logic [32:0]       free_q, free_d;
  logic [31:0]       v_q, v_d;
  logic [RW-1:0]     g_addr_q, g_addr_d, g_idx_q, g_idx_d, u_q, u_d;
  logic              g_pend_q, g_pend_d;
  logic [63:0]       prev_q, prev_d, cur_q, cur_d;
  logic              has_p_q, has_p_d, has_u_q, has_u_d;
  logic [RW-1:0]     sh_cnt_q, sh_cnt_d, sh_src_q, sh_src_d, sh_dst_q, sh_dst_d;
  logic              sh_up_q, sh_up_d, sh_pend_q, sh_pend_d;
  rcia_pkg::after_e  after_q, after_d;
  rcia_pkg::status_e res_status_q, res_status_d;
  logic [31:0]       res_id_q, res_id_d;
  logic [KEY_BITS-1:0] res_key_q, res_key_d;
  logic              out_valid_q, out_valid_d;
  rcia_pkg::rsp_t    out_q, out_d;

  // Shared decode
  logic                in_acc;
  logic [KEY_BITS-1:0] e_key;
  logic [31:0]         e_id, e_mark, age;
  logic                cur_valid, cur_pend, hit_cond;
  logic                scan_issue, scan_hit, scan_end;
  logic [31:0]         r_start, r_end;
  logic                g_issue, g_stop, g_end, join_p, join_u;
  logic                sh_issue, sh_done, out_free;

  assign in_ready_o = (state_q == rcia_pkg::S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign e_key     = e_rdata[EW-1 -: KEY_BITS];
  assign e_id      = e_rdata[63:32];
  assign e_mark    = e_rdata[31:0];
  assign age       = tick_q - e_mark;
  assign cur_valid = valid_q[rd_idx_q];
  assign cur_pend  = pend_q[rd_idx_q];

  // Per-request match condition on the entry being read
  always_comb begin
    unique case (op_q)
      rcia_pkg::REQ_GET_ID,
      rcia_pkg::REQ_ERASE:     hit_cond = cur_valid && (e_key == key_q);
      rcia_pkg::REQ_ID_TO_KEY: hit_cond = cur_valid && (e_id == qid_q);
      rcia_pkg::REQ_CLEANUP:   hit_cond = cur_valid && cur_pend && (age > cfg.release_delay);
      default:                 hit_cond = 1'b0;
    endcase
  end

  assign scan_issue = (state_q == rcia_pkg::S_SCAN) &&
                      (scan_addr_q < (AW+1)'(MAX_ENTRIES));
  assign scan_hit   = (state_q == rcia_pkg::S_SCAN) && rd_pend_q && hit_cond;
  assign scan_end   = (state_q == rcia_pkg::S_SCAN) && !rd_pend_q &&
                      (scan_addr_q >= (AW+1)'(MAX_ENTRIES));

  assign r_start  = r_rdata[63:32];
  assign r_end    = r_rdata[31:0];
  assign g_issue  = (state_q == rcia_pkg::S_GB_SCAN) && (g_addr_q < used_q);
  assign g_stop   = (state_q == rcia_pkg::S_GB_SCAN) && g_pend_q && (r_start > v_q);
  assign g_end    = (state_q == rcia_pkg::S_GB_SCAN) && !g_pend_q && (g_addr_q >= used_q);
  assign join_p   = has_p_q && (({1'b0, prev_q[31:0]} + 33'd1) == {1'b0, v_q});
  assign join_u   = has_u_q && (({1'b0, v_q} + 33'd1) == {1'b0, cur_q[63:32]});
  assign sh_issue = (state_q == rcia_pkg::S_SHIFT) && (sh_cnt_q != '0);
  assign sh_done  = (state_q == rcia_pkg::S_SHIFT) && (sh_cnt_q == '0) && !sh_pend_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rcia_pkg::S_INIT: state_d = rcia_pkg::S_IDLE;
      rcia_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.req_type == rcia_pkg::REQ_GET_ID ||
              in_data_i.req_type == rcia_pkg::REQ_ID_TO_KEY ||
              in_data_i.req_type == rcia_pkg::REQ_ERASE ||
              in_data_i.req_type == rcia_pkg::REQ_CLEANUP) begin
            state_d = rcia_pkg::S_SCAN;
          end else begin
            state_d = rcia_pkg::S_DONE;
          end
        end
      end
      rcia_pkg::S_SCAN: begin
        if (scan_hit) begin
          state_d = (op_q == rcia_pkg::REQ_CLEANUP) ? rcia_pkg::S_GB_SCAN : rcia_pkg::S_DONE;
        end else if (scan_end) begin
          if (op_q == rcia_pkg::REQ_GET_ID && used_q != '0 && free_found_q) begin
            state_d = rcia_pkg::S_ALLOC_RD;
          end else begin
            state_d = rcia_pkg::S_DONE;
          end
        end
      end
      rcia_pkg::S_ALLOC_RD: state_d = rcia_pkg::S_ALLOC_UPD;
      rcia_pkg::S_ALLOC_UPD: begin
        state_d = (r_start < r_end) ? rcia_pkg::S_DONE : rcia_pkg::S_SHIFT;
      end
      rcia_pkg::S_GB_SCAN: begin
        if (g_stop || g_end) begin
          state_d = rcia_pkg::S_GB_ACT;
        end
      end
      rcia_pkg::S_GB_ACT: begin
        priority if (join_p && join_u) state_d = rcia_pkg::S_SHIFT;
        else if (join_p || join_u)     state_d = rcia_pkg::S_SCAN;
        else if (used_q < RW'(SLOTS))  state_d = rcia_pkg::S_SHIFT;
        else                           state_d = rcia_pkg::S_SCAN;
      end
      rcia_pkg::S_SHIFT: begin
        if (sh_done) begin
          unique case (after_q)
            rcia_pkg::AFT_DONE: state_d = rcia_pkg::S_DONE;
            rcia_pkg::AFT_SCAN: state_d = rcia_pkg::S_SCAN;
            rcia_pkg::AFT_INS:  state_d = rcia_pkg::S_INS;
            default:            state_d = rcia_pkg::S_DONE;
          endcase
        end
      end
      rcia_pkg::S_INS: state_d = rcia_pkg::S_SCAN;
      rcia_pkg::S_DONE: begin
        if (out_free) begin
          state_d = rcia_pkg::S_IDLE;
        end
      end
      default: state_d = rcia_pkg::S_INIT;
    endcase
    if (cfg_rebuild) begin
      state_d = rcia_pkg::S_INIT;
    end
  end

  // Datapath and memory control
  always_comb begin
    op_d         = op_q;
    key_d        = key_q;
    qid_d        = qid_q;
    valid_d      = valid_q;
    pend_d       = pend_q;
    scan_addr_d  = scan_addr_q;
    rd_pend_d    = 1'b0;
    rd_idx_d     = rd_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    tick_d       = tick_q;
    used_d       = used_q;
    free_d       = free_q;
    v_d          = v_q;
    g_addr_d     = g_addr_q;
    g_pend_d     = 1'b0;
    g_idx_d      = g_idx_q;
    u_d          = u_q;
    prev_d       = prev_q;
    cur_d        = cur_q;
    has_p_d      = has_p_q;
    has_u_d      = has_u_q;
    sh_cnt_d     = sh_cnt_q;
    sh_src_d     = sh_src_q;
    sh_dst_d     = sh_dst_q;
    sh_up_d      = sh_up_q;
    sh_pend_d    = 1'b0;
    after_d      = after_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_key_d    = res_key_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    e_we         = 1'b0;
    e_waddr      = rd_idx_q;
    e_wdata      = e_rdata;
    e_re         = 1'b0;
    e_raddr      = scan_addr_q[AW-1:0];
    r_we         = 1'b0;
    r_waddr      = '0;
    r_wdata      = r_rdata;
    r_re         = 1'b0;
    r_raddr      = '0;

    unique case (state_q)
      // Write the initial free range
      rcia_pkg::S_INIT: begin
        r_we    = 1'b1;
        r_wdata = {cfg.min_id, cfg.max_id};
        if (cfg.min_id <= cfg.max_id) begin
          used_d = RW'(1);
          free_d = {1'b0, cfg.max_id} - {1'b0, cfg.min_id} + 33'd1;
        end else begin
          used_d = '0;
          free_d = '0;
        end
      end

      rcia_pkg::S_IDLE: begin
        if (in_acc) begin
          op_d         = in_data_i.req_type;
          key_d        = in_data_i.key[KEY_BITS-1:0];
          qid_d        = in_data_i.query_id;
          scan_addr_d  = '0;
          free_found_d = 1'b0;
          res_status_d = rcia_pkg::STAT_NOT_FOUND;
          res_id_d     = '0;
          res_key_d    = '0;
          if (in_data_i.req_type == rcia_pkg::REQ_TICK) begin
            tick_d       = tick_q + 32'd1;
            res_status_d = rcia_pkg::STAT_DONE;
          end
        end
      end

      // Pipelined entry scan: issue one read, check the previous one
      rcia_pkg::S_SCAN: begin
        if (scan_issue) begin
          e_re        = 1'b1;
          scan_addr_d = scan_addr_q + (AW+1)'(1);
          rd_pend_d   = 1'b1;
          rd_idx_d    = scan_addr_q[AW-1:0];
        end
        if (rd_pend_q && !cur_valid && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = rd_idx_q;
        end
        if (scan_hit) begin
          rd_pend_d = 1'b0;
          unique case (op_q)
            rcia_pkg::REQ_GET_ID: begin
              pend_d[rd_idx_q] = 1'b0;
              res_status_d     = rcia_pkg::STAT_EXISTING;
              res_id_d         = e_id;
            end
            rcia_pkg::REQ_ID_TO_KEY: begin
              res_status_d = rcia_pkg::STAT_DONE;
              res_id_d     = qid_q;
              res_key_d    = e_key;
            end
            rcia_pkg::REQ_ERASE: begin
              if (!cur_pend) begin
                pend_d[rd_idx_q] = 1'b1;
                e_we             = 1'b1;
                e_wdata          = {e_key, e_id, tick_q};
              end
              res_status_d = rcia_pkg::STAT_DONE;
            end
            rcia_pkg::REQ_CLEANUP: begin
              v_d               = e_id;
              valid_d[rd_idx_q] = 1'b0;
              pend_d[rd_idx_q]  = 1'b0;
              scan_addr_d       = {1'b0, rd_idx_q} + (AW+1)'(1);
              g_addr_d          = '0;
              has_p_d           = 1'b0;
              has_u_d           = 1'b0;
            end
            default: ;
          endcase
        end else if (scan_end) begin
          if (op_q == rcia_pkg::REQ_GET_ID) begin
            if (used_q == '0) begin
              res_status_d = rcia_pkg::STAT_NO_FREE;
            end else if (!free_found_q) begin
              res_status_d = rcia_pkg::STAT_FULL;
            end
          end else if (op_q == rcia_pkg::REQ_CLEANUP) begin
            res_status_d = rcia_pkg::STAT_DONE;
          end
        end
      end

      rcia_pkg::S_ALLOC_RD: begin
        r_re = 1'b1;
      end

      // Take the lowest free ID from the first range
      rcia_pkg::S_ALLOC_UPD: begin
        e_we                = 1'b1;
        e_waddr             = free_idx_q;
        e_wdata             = {key_q, r_start, 32'h0};
        valid_d[free_idx_q] = 1'b1;
        pend_d[free_idx_q]  = 1'b0;
        free_d              = free_q - 33'd1;
        res_status_d        = rcia_pkg::STAT_NEW;
        res_id_d            = r_start;
        if (r_start < r_end) begin
          r_we    = 1'b1;
          r_wdata = {r_start + 32'd1, r_end};
        end else begin
          sh_cnt_d = used_q - RW'(1);
          sh_src_d = RW'(1);
          sh_up_d  = 1'b0;
          after_d  = rcia_pkg::AFT_DONE;
          used_d   = used_q - RW'(1);
        end
      end

      // Walk the ranges to find the first start above the freed ID
      rcia_pkg::S_GB_SCAN: begin
        r_raddr = g_addr_q[RAW-1:0];
        if (g_issue && !g_stop) begin
          r_re     = 1'b1;
          g_addr_d = g_addr_q + RW'(1);
          g_pend_d = 1'b1;
          g_idx_d  = g_addr_q;
        end
        if (g_pend_q && !g_stop) begin
          prev_d  = r_rdata;
          has_p_d = 1'b1;
        end
        if (g_stop) begin
          cur_d   = r_rdata;
          has_u_d = 1'b1;
          u_d     = g_idx_q;
        end else if (g_end) begin
          u_d = used_q;
        end
      end

      // Merge or insert the freed ID, or drop it when no neighbour joins and all slots are used
      rcia_pkg::S_GB_ACT: begin
        priority if (join_p && join_u) begin
          r_we     = 1'b1;
          r_waddr  = RAW'(u_q - RW'(1));
          r_wdata  = {prev_q[63:32], cur_q[31:0]};
          sh_cnt_d = used_q - RW'(1) - u_q;
          sh_src_d = u_q + RW'(1);
          sh_up_d  = 1'b0;
          after_d  = rcia_pkg::AFT_SCAN;
          used_d   = used_q - RW'(1);
          free_d   = free_q + 33'd1;
        end else if (join_p) begin
          r_we    = 1'b1;
          r_waddr = RAW'(u_q - RW'(1));
          r_wdata = {prev_q[63:32], v_q};
          free_d  = free_q + 33'd1;
        end else if (join_u) begin
          r_we    = 1'b1;
          r_waddr = RAW'(u_q);
          r_wdata = {v_q, cur_q[31:0]};
          free_d  = free_q + 33'd1;
        end else if (used_q < RW'(SLOTS)) begin
          sh_cnt_d = used_q - u_q;
          sh_src_d = used_q - RW'(1);
          sh_up_d  = 1'b1;
          after_d  = rcia_pkg::AFT_INS;
          used_d   = used_q + RW'(1);
          free_d   = free_q + 33'd1;
        end
      end

      // Move a block of ranges by one slot, one per cycle
      rcia_pkg::S_SHIFT: begin
        r_raddr = sh_src_q[RAW-1:0];
        if (sh_issue) begin
          r_re      = 1'b1;
          sh_pend_d = 1'b1;
          sh_cnt_d  = sh_cnt_q - RW'(1);
          if (sh_up_q) begin
            sh_dst_d = sh_src_q + RW'(1);
            sh_src_d = sh_src_q - RW'(1);
          end else begin
            sh_dst_d = sh_src_q - RW'(1);
            sh_src_d = sh_src_q + RW'(1);
          end
        end
        if (sh_pend_q) begin
          r_we    = 1'b1;
          r_waddr = sh_dst_q[RAW-1:0];
          r_wdata = r_rdata;
        end
      end

      rcia_pkg::S_INS: begin
        r_we    = 1'b1;
        r_waddr = RAW'(u_q);
        r_wdata = {v_q, v_q};
      end

      rcia_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.status        = res_status_q;
          out_d.id            = res_id_q;
          out_d.found_key     = 64'(res_key_q);
          out_d.remaining_ids = free_q;
          out_d.range_count   = 9'(used_q);
        end
      end

      default: ;
    endcase

    // Bound rewrite drops all entries and marks
    if (cfg_rebuild) begin
      valid_d = '0;
      pend_d  = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rcia_pkg::S_INIT;
      valid_q     <= '0;
      pend_q      <= '0;
      rd_pend_q   <= 1'b0;
      g_pend_q    <= 1'b0;
      sh_pend_q   <= 1'b0;
      tick_q      <= '0;
      used_q      <= '0;
      free_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      pend_q      <= pend_d;
      rd_pend_q   <= rd_pend_d;
      g_pend_q    <= g_pend_d;
      sh_pend_q   <= sh_pend_d;
      tick_q      <= tick_d;
      used_q      <= used_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    qid_q        <= qid_d;
    scan_addr_q  <= scan_addr_d;
    rd_idx_q     <= rd_idx_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    v_q          <= v_d;
    g_addr_q     <= g_addr_d;
    g_idx_q      <= g_idx_d;
    u_q          <= u_d;
    prev_q       <= prev_d;
    cur_q        <= cur_d;
    has_p_q      <= has_p_d;
    has_u_q      <= has_u_d;
    sh_cnt_q     <= sh_cnt_d;
    sh_src_q     <= sh_src_d;
    sh_dst_q     <= sh_dst_d;
    sh_up_q      <= sh_up_d;
    after_q      <= after_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_key_q    <= res_key_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // Range count never exceeds the slot count
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= RW'(SLOTS))
    else $error("range count above slot count");

  // An empty range list holds no free IDs
  a_empty_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q == '0) |-> (free_q == '0))
    else $error("free total nonzero with no ranges");

  // No RAM read is outstanding when a new transaction can be taken
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!rd_pend_q && !g_pend_q && !sh_pend_q))
    else $error("read in flight while idle");

  // A result is only loaded from the done state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == rcia_pkg::S_DONE))
    else $error("result loaded outside done state");
`endif

endmodule

// File: verif/range_coalescing_id_allocator_core_tb.sv
// Self-checking testbench for range_coalescing_id_allocator_core.
// Drives requests and APB register writes, predicts every response with a local allocator model.
// Depends on rcia_pkg and the core RTL.
module range_coalescing_id_allocator_core_tb;

  localparam int unsigned NUM_ENTRIES = 256;
  localparam int unsigned NUM_SLOTS   = NUM_ENTRIES + 1;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  rcia_pkg::req_t              in_data_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  rcia_pkg::rsp_t              out_data_o;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [rcia_pkg::CFG_AW-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  range_coalescing_id_allocator_core #(
    .MAX_ENTRIES(NUM_ENTRIES),
    .KEY_BITS   (64)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Allocator state mirror
  logic [63:0] ent_key  [NUM_ENTRIES];
  logic [31:0] ent_id   [NUM_ENTRIES];
  bit          ent_valid[NUM_ENTRIES];
  bit          ent_pend [NUM_ENTRIES];
  logic [31:0] ent_mark [NUM_ENTRIES];
  logic [31:0] free_lo  [NUM_SLOTS];
  logic [31:0] free_hi  [NUM_SLOTS];
  int unsigned free_ranges;
  logic [31:0] tick_now;
  logic [32:0] free_ids;
  logic [31:0] bound_lo, bound_hi, hold_ticks;

  rcia_pkg::req_t pending_reqs[$];
  rcia_pkg::rsp_t expected_rsps[$];
  logic [63:0]    key_pool[$];
  int             err_cnt;
  int             accepted_cnt;
  int             send_idle, recv_idle;

  // Drop all bindings and restore the single initial free range, or none if the bounds are inverted
  function automatic void rebuild_free_list();
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      ent_valid[i] = 1'b0;
      ent_pend[i]  = 1'b0;
    end
    if (bound_lo <= bound_hi) begin
      free_lo[0]  = bound_lo;
      free_hi[0]  = bound_hi;
      free_ranges = 1;
      free_ids    = {1'b0, bound_hi} - {1'b0, bound_lo} + 33'd1;
    end else begin
      free_ranges = 0;
      free_ids    = '0;
    end
  endfunction

  function automatic int find_binding(logic [63:0] k);
    for (int i = 0; i < NUM_ENTRIES; i++)
      if (ent_valid[i] && ent_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void drop_range(int unsigned r);
    for (int unsigned j = r; j + 1 < free_ranges; j++) begin
      free_lo[j] = free_lo[j+1];
      free_hi[j] = free_hi[j+1];
    end
    if (free_ranges > 0) free_ranges--;
  endfunction

  // Return an ID to the sorted free list, merging with neighbors; dropped if the list is full and none joins
  function automatic void return_id(logic [31:0] v);
    int unsigned u;
    bit join_p, join_u;
    u = 0;
    while (u < free_ranges && free_lo[u] <= v) u++;
    join_p = (u > 0) && ({1'b0, free_hi[u-1]} + 33'd1 == {1'b0, v});
    join_u = (u < free_ranges) && ({1'b0, v} + 33'd1 == {1'b0, free_lo[u]});
    if (join_p && join_u) begin
      free_hi[u-1] = free_hi[u];
      drop_range(u);
    end else if (join_p) begin
      free_hi[u-1] = v;
    end else if (join_u) begin
      free_lo[u] = v;
    end else if (free_ranges < NUM_SLOTS) begin
      for (int unsigned j = free_ranges; j > u; j--) begin
        free_lo[j] = free_lo[j-1];
        free_hi[j] = free_hi[j-1];
      end
      free_lo[u] = v;
      free_hi[u] = v;
      free_ranges++;
    end else begin
      return;
    end
    free_ids++;
  endfunction

  // Apply one request to the mirror and build its response
  function automatic rcia_pkg::rsp_t serve_request(rcia_pkg::req_t rq);
    rcia_pkg::rsp_t rs;
    int e, i;
    rs = '0;
    rs.status = rcia_pkg::STAT_NOT_FOUND;
    case (rq.req_type)
      rcia_pkg::REQ_GET_ID: begin
        e = find_binding(rq.key);
        if (e >= 0) begin
          ent_pend[e] = 1'b0;
          rs.status = rcia_pkg::STAT_EXISTING;
          rs.id = ent_id[e];
        end else if (free_ranges == 0) begin
          rs.status = rcia_pkg::STAT_NO_FREE;
        end else begin
          i = 0;
          while (i < NUM_ENTRIES && ent_valid[i]) i++;
          if (i >= NUM_ENTRIES) begin
            rs.status = rcia_pkg::STAT_FULL;
          end else begin
            rs.id = free_lo[0];
            if (free_lo[0] < free_hi[0]) free_lo[0]++;
            else drop_range(0);
            free_ids--;
            ent_valid[i] = 1'b1;
            ent_pend[i]  = 1'b0;
            ent_key[i]   = rq.key;
            ent_id[i]    = rs.id;
            rs.status    = rcia_pkg::STAT_NEW;
          end
        end
      end
      rcia_pkg::REQ_ID_TO_KEY: begin
        for (i = 0; i < NUM_ENTRIES; i++) begin
          if (ent_valid[i] && ent_id[i] == rq.query_id) begin
            rs.status = rcia_pkg::STAT_DONE;
            rs.id = rq.query_id;
            rs.found_key = ent_key[i];
            break;
          end
        end
      end
      rcia_pkg::REQ_ERASE: begin
        e = find_binding(rq.key);
        if (e >= 0) begin
          if (!ent_pend[e]) begin
            ent_pend[e] = 1'b1;
            ent_mark[e] = tick_now;
          end
          rs.status = rcia_pkg::STAT_DONE;
        end
      end
      rcia_pkg::REQ_TICK: begin
        tick_now++;
        rs.status = rcia_pkg::STAT_DONE;
      end
      rcia_pkg::REQ_CLEANUP: begin
        for (i = 0; i < NUM_ENTRIES; i++) begin
          if (ent_valid[i] && ent_pend[i] && (tick_now - ent_mark[i]) > hold_ticks) begin
            return_id(ent_id[i]);
            ent_valid[i] = 1'b0;
            ent_pend[i]  = 1'b0;
          end
        end
        rs.status = rcia_pkg::STAT_DONE;
      end
      default: ;
    endcase
    rs.remaining_ids = free_ids;
    rs.range_count   = free_ranges[8:0];
    return rs;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
    err_cnt++;
  endtask

  // Idle rates by stage of the run
  always @* begin
    if (accepted_cnt < 450) begin
      send_idle = 36;
      recv_idle = 78;
    end else if (accepted_cnt < 900) begin
      send_idle = 78;
      recv_idle = 36;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
  end

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_rsps.push_back(serve_request(in_data_i));
        accepted_cnt++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_reqs.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Response monitor
  always @(posedge clk_i or negedge rst_ni) begin
    rcia_pkg::rsp_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected transaction", out_data_o.status, 0);
        end else begin
          want = expected_rsps.pop_front();
          if (out_data_o.status !== want.status)
            report_mismatch("status", out_data_o.status, want.status);
          if (out_data_o.id !== want.id)
            report_mismatch("id", out_data_o.id, want.id);
          if (out_data_o.found_key !== want.found_key)
            report_mismatch("found_key", out_data_o.found_key, want.found_key);
          if (out_data_o.remaining_ids !== want.remaining_ids)
            report_mismatch("remaining_ids", out_data_o.remaining_ids, want.remaining_ids);
          if (out_data_o.range_count !== want.range_count)
            report_mismatch("range_count", out_data_o.range_count, want.range_count);
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Sampled mid-cycle so a transaction being offered still counts as in flight
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || in_valid_i)
      @(negedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // APB write: setup then access; mirror updated when the write lands
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= rcia_pkg::CFG_AW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      rcia_pkg::REG_MIN_ID: begin
        bound_lo = val;
        rebuild_free_list();
      end
      rcia_pkg::REG_MAX_ID: begin
        bound_hi = val;
        rebuild_free_list();
      end
      default: hold_ticks = val;
    endcase
  endtask

  task automatic queue_req(logic [2:0] op, logic [63:0] k, logic [31:0] q);
    rcia_pkg::req_t rq;
    rq.req_type = op;
    rq.key      = k;
    rq.query_id = q;
    pending_reqs.push_back(rq);
  endtask

  task automatic refill_keys(int n);
    key_pool.delete();
    for (int i = 0; i < n; i++) key_pool.push_back({$urandom, $urandom});
  endtask

  // Mixed traffic over a small key pool so keys recur
  task automatic queue_random(int n);
    logic [63:0] k;
    logic [31:0] q;
    int pick;
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                   : key_pool[$urandom_range(key_pool.size() - 1)];
      q = ($urandom_range(3) == 0) ? $urandom : bound_lo + $urandom_range(40);
      pick = $urandom_range(99);
      if (pick < 35)      queue_req(rcia_pkg::REQ_GET_ID, k, q);
      else if (pick < 50) queue_req(rcia_pkg::REQ_ID_TO_KEY, k, q);
      else if (pick < 70) queue_req(rcia_pkg::REQ_ERASE, k, q);
      else if (pick < 85) queue_req(rcia_pkg::REQ_TICK, k, q);
      else if (pick < 95) queue_req(rcia_pkg::REQ_CLEANUP, k, q);
      else                queue_req(3'($urandom_range(7, 5)), k, q);
    end
  endtask

  initial begin
    logic [63:0] k0, k1;
    err_cnt = 0;
    accepted_cnt = 0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    bound_lo = rcia_pkg::MIN_ID_RST;
    bound_hi = rcia_pkg::MAX_ID_RST;
    hold_ticks = rcia_pkg::RELEASE_DELAY_RST;
    tick_now = '0;
    rebuild_free_list();
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every request, repeat/cancel, unknown codes
    k0 = '0;
    k1 = '1;
    queue_req(rcia_pkg::REQ_GET_ID, k0, '0);
    queue_req(rcia_pkg::REQ_GET_ID, k1, '1);
    queue_req(rcia_pkg::REQ_GET_ID, k0, '0);
    queue_req(rcia_pkg::REQ_ID_TO_KEY, k0, 32'd0);
    queue_req(rcia_pkg::REQ_ID_TO_KEY, k1, 32'd1);
    queue_req(rcia_pkg::REQ_ID_TO_KEY, k0, '1);
    queue_req(rcia_pkg::REQ_ERASE, 64'h5a5a_0000_1234_ffff, '0);
    queue_req(rcia_pkg::REQ_ERASE, k0, '0);
    queue_req(rcia_pkg::REQ_TICK, k0, '0);
    queue_req(rcia_pkg::REQ_ERASE, k0, '0);
    queue_req(rcia_pkg::REQ_GET_ID, k0, '0);
    queue_req(rcia_pkg::REQ_ERASE, k0, '0);
    queue_req(rcia_pkg::REQ_CLEANUP, k0, '0);
    queue_req(3'd5, k1, '1);
    queue_req(3'd6, k0, '0);
    queue_req(3'd7, k1, '1);
    wait_drained();
    write_reg(rcia_pkg::REG_RELEASE_DELAY, 32'd0);
    queue_req(rcia_pkg::REQ_TICK, k0, '0);
    queue_req(rcia_pkg::REQ_CLEANUP, k0, '0);
    queue_req(rcia_pkg::REQ_ID_TO_KEY, k0, 32'd0);
    queue_req(rcia_pkg::REQ_GET_ID, 64'h8000_0000_0000_0001, '0);
    wait_drained();

    // Small window, short hold-off
    write_reg(rcia_pkg::REG_MIN_ID, 32'd10);
    write_reg(rcia_pkg::REG_MAX_ID, 32'd20);
    write_reg(rcia_pkg::REG_RELEASE_DELAY, 32'd2);
    refill_keys(20);
    queue_random(150);
    wait_drained();
    // Sender holds until all responses are back
    queue_random(150);
    wait_drained();

    // Single ID at the top of the range, marks never expire
    write_reg(rcia_pkg::REG_MAX_ID, '1);
    write_reg(rcia_pkg::REG_MIN_ID, '1);
    write_reg(rcia_pkg::REG_RELEASE_DELAY, '1);
    refill_keys(6);
    queue_random(150);
    wait_drained();

    // Inverted bounds: empty free list
    write_reg(rcia_pkg::REG_MIN_ID, 32'd5);
    write_reg(rcia_pkg::REG_MAX_ID, 32'd3);
    refill_keys(4);
    queue_random(60);
    wait_drained();

    // Fill the entry table past capacity, then churn
    write_reg(rcia_pkg::REG_MIN_ID, 32'd0);
    write_reg(rcia_pkg::REG_MAX_ID, 32'd1000);
    write_reg(rcia_pkg::REG_RELEASE_DELAY, 32'd0);
    refill_keys(260);
    for (int i = 0; i < 260; i++) queue_req(rcia_pkg::REQ_GET_ID, key_pool[i], $urandom);
    queue_random(100);
    wait_drained();

    // Fragmented free list
    write_reg(rcia_pkg::REG_MIN_ID, 32'd100);
    write_reg(rcia_pkg::REG_MAX_ID, 32'd400);
    write_reg(rcia_pkg::REG_RELEASE_DELAY, 32'd3);
    refill_keys(40);
    queue_random(380);
    wait_drained();

    repeat (600) @(posedge clk_i);
    if (err_cnt == 0 && expected_rsps.size() == 0) begin
      $display("range_coalescing_id_allocator_core verification clean");
    end else begin
      $display("range_coalescing_id_allocator_core verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(20 * 4_000_000);
    $display("range_coalescing_id_allocator_core verification failed");
    $finish;
  end

endmodule

// File: files.f
design/rcia_pkg.sv
design/rcia_ram.sv
design/rcia_cfg.sv
design/range_coalescing_id_allocator_core.sv
verif/range_coalescing_id_allocator_core_tb.sv
